@@ sv/erg_pkg.sv @@
`default_nettype none

package erg_pkg;

    // Longest pattern the cell row can hold
    localparam int MAX_STEPS  = 64;
    localparam int STEP_IDX_W = $clog2(MAX_STEPS);

    // Field widths
    localparam int COUNT_W = 7;
    localparam int ROT_W   = 8;
    localparam int MASK_W  = 64;

    // Offset reduction runs one quotient bit per cycle
    localparam int MOD_STEPS_W = 3;
    localparam int TRIAL_W     = COUNT_W + ROT_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DONE
    } state_t;

    // Control shared by every cell of the row
    typedef struct packed {
        logic clr;
        logic shift;
        logic ins_bit;
    } chain_ctl_t;

endpackage

`default_nettype wire

@@ sv/euclidean_rhythm_rotate.sv @@
// An accepted word first has its rotation r reduced modulo the step count s (r is
// at most 63); an empty result goes straight to the output register.
// One word at a time: the offset reduction runs first, then the accumulator runs
// r + s steps, and the cell row shifts in the last s of them.
// A finished result waits in an output register while the next word is taken.
// Reset (rst_n, asynchronous, active low) returns to idle with no result pending.
`default_nettype none

module euclidean_rhythm_rotate (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [erg_pkg::COUNT_W-1:0]        hit_count,
    input  wire logic [erg_pkg::COUNT_W-1:0]        step_count,
    input  wire logic signed [erg_pkg::ROT_W-1:0]   rotate_by,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [erg_pkg::MASK_W-1:0]              rhythm_mask
);

    erg_pkg::state_t                    state_reg;
    erg_pkg::state_t                    state_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [erg_pkg::COUNT_W-1:0]        h_reg;
    logic [erg_pkg::COUNT_W-1:0]        s_reg;
    logic [erg_pkg::COUNT_W-1:0]        acc_reg;
    logic [erg_pkg::COUNT_W-1:0]        acc_next;
    logic [erg_pkg::COUNT_W-1:0]        cnt_reg;
    logic [erg_pkg::COUNT_W-1:0]        cnt_next;
    logic [erg_pkg::STEP_IDX_W-1:0]     rot_reg;
    logic [erg_pkg::COUNT_W-1:0]        end_reg;
    logic [erg_pkg::MASK_W-1:0]         mask_reg;

    logic                               in_take;
    logic                               out_load;
    logic [erg_pkg::COUNT_W-1:0]        hits_clamped;
    logic                               pattern_ok;
    logic                               mod_done;
    logic [erg_pkg::STEP_IDX_W-1:0]     mod_rot;
    logic [erg_pkg::COUNT_W-1:0]        acc_sum;
    logic                               hit;
    logic [erg_pkg::STEP_IDX_W-1:0]     tail_idx;
    erg_pkg::chain_ctl_t                chain_ctl;
    logic [erg_pkg::MAX_STEPS-1:0]      cell_q;
    logic [erg_pkg::MAX_STEPS:0]        cell_right;

    assign in_stall    = (state_reg != erg_pkg::ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign rhythm_mask = mask_reg;

    // Clamp hits; empty results skip straight to delivery
    assign hits_clamped = (hit_count > step_count) ? step_count : hit_count;
    assign pattern_ok   = (step_count != '0)
                          && (step_count <= erg_pkg::COUNT_W'(erg_pkg::MAX_STEPS))
                          && (hits_clamped != '0);

    // Offset reduction modulo the step count
    erg_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_take && pattern_ok),
        .offset (rotate_by),
        .steps  (step_count),
        .done   (mod_done),
        .rot    (mod_rot)
    );

    // Bucket-fill accumulator, one step per cycle
    assign acc_sum = acc_reg + h_reg;
    assign hit     = (acc_sum >= s_reg);

    // Output register load when empty or being drained
    assign out_load = (state_reg == erg_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        chain_ctl      = '{clr: 1'b0, shift: 1'b0, ins_bit: hit};
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            erg_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    chain_ctl.clr = 1'b1;
                    acc_next      = step_count - hits_clamped;
                    state_next    = pattern_ok ? erg_pkg::ST_MOD : erg_pkg::ST_DONE;
                end
            end
            erg_pkg::ST_MOD:
            begin
                cnt_next = '0;
                if (mod_done)
                begin
                    state_next = erg_pkg::ST_RUN;
                end
            end
            erg_pkg::ST_RUN:
            begin
                // Steps before the rotation only advance the accumulator
                acc_next        = hit ? (acc_sum - s_reg) : acc_sum;
                chain_ctl.shift = (cnt_reg >= erg_pkg::COUNT_W'(rot_reg));
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == end_reg)
                begin
                    state_next = erg_pkg::ST_DONE;
                end
            end
            erg_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = erg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = erg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= erg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        if (in_take)
        begin
            h_reg <= hits_clamped;
            s_reg <= step_count;
        end
        if (mod_done)
        begin
            rot_reg <= mod_rot;
            end_reg <= erg_pkg::COUNT_W'(mod_rot) + s_reg - 1'b1;
        end
        if (out_load)
        begin
            mask_reg <= erg_pkg::MASK_W'(cell_q);
        end
    end

    // Row of cells; the cell at step count - 1 takes the new bit
    assign tail_idx = erg_pkg::STEP_IDX_W'(s_reg - 1'b1);
    assign cell_right[erg_pkg::MAX_STEPS] = 1'b0;

    for (genvar k = 0; k < erg_pkg::MAX_STEPS; k++)
    begin : g_cell
        erg_cell u_cell (
            .clk       (clk),
            .ctl       (chain_ctl),
            .is_tail   (tail_idx == erg_pkg::STEP_IDX_W'(k)),
            .right_bit (cell_right[k+1]),
            .bit_q     (cell_q[k])
        );
        assign cell_right[k] = cell_q[k];
    end

`ifndef ASSERT_OFF
    // A taken word blocks the input until its result is loaded into the output register
    a_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input not stalled after taking a word");

    // Accumulator stays below the step count while running
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == erg_pkg::ST_RUN) |-> (acc_reg < s_reg))
        else $error("accumulator out of range");

    // Step counter never passes its end mark
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == erg_pkg::ST_RUN) |-> (cnt_reg <= end_reg))
        else $error("step counter overran");

    // A pending result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(mask_reg)))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

@@ sv/erg_cell.sv @@
`default_nettype none

module erg_cell (
    input  wire logic              clk,
    input  wire erg_pkg::chain_ctl_t ctl,
    input  wire logic              is_tail,
    input  wire logic              right_bit,
    output logic                   bit_q
);

    logic bit_reg;
    logic bit_next;

    // On a shift the tail cell takes the new hit bit, the others their right neighbor; clr zeroes the cell
    always_comb
    begin
        bit_next = bit_reg;
        if (ctl.clr)
        begin
            bit_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            bit_next = is_tail ? ctl.ins_bit : right_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_q = bit_reg;

endmodule

`default_nettype wire

@@ sv/erg_mod.sv @@
`default_nettype none

module erg_mod (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic signed [erg_pkg::ROT_W-1:0]   offset,
    input  wire logic [erg_pkg::COUNT_W-1:0]        steps,
    output logic                                    done,
    output logic [erg_pkg::STEP_IDX_W-1:0]          rot
);

    logic                               busy_reg;
    logic                               busy_next;
    logic [erg_pkg::MOD_STEPS_W-1:0]    k_reg;
    logic [erg_pkg::MOD_STEPS_W-1:0]    k_next;
    logic [erg_pkg::ROT_W-1:0]          rem_reg;
    logic [erg_pkg::ROT_W-1:0]          rem_next;
    logic                               neg_reg;
    logic [erg_pkg::COUNT_W-1:0]        s_reg;
    logic [erg_pkg::ROT_W-1:0]          off_mag;
    logic [erg_pkg::TRIAL_W-1:0]        trial;
    logic [erg_pkg::ROT_W-1:0]          rem_step;
    logic [erg_pkg::COUNT_W-1:0]        wrap;

    // Magnitude of the offset; -128 maps to 128
    assign off_mag = offset[erg_pkg::ROT_W-1] ? erg_pkg::ROT_W'(~offset + 1'b1)
                                               : erg_pkg::ROT_W'(offset);

    // One restoring step: subtract steps << k when it fits
    assign trial    = erg_pkg::TRIAL_W'(s_reg) << k_reg;
    assign rem_step = (erg_pkg::TRIAL_W'(rem_reg) >= trial)
                      ? erg_pkg::ROT_W'(rem_reg - trial[erg_pkg::ROT_W-1:0])
                      : rem_reg;

    // Negative offsets with a nonzero remainder wrap to steps - remainder
    assign wrap = s_reg - rem_step[erg_pkg::COUNT_W-1:0];
    assign done = busy_reg && (k_reg == '0);
    assign rot  = (neg_reg && (rem_step != '0)) ? wrap[erg_pkg::STEP_IDX_W-1:0]
                                                : rem_step[erg_pkg::STEP_IDX_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            busy_next = 1'b1;
            k_next    = '1;
            rem_next  = off_mag;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            k_next   = k_reg - 1'b1;
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (load)
        begin
            neg_reg <= offset[erg_pkg::ROT_W-1];
            s_reg   <= steps;
        end
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_WORDS = 1500;
    localparam int SETTLE_CYCLES = 200;

    // One request word as queued for the driver
    typedef struct {
        logic [erg_pkg::COUNT_W-1:0]       hits;
        logic [erg_pkg::COUNT_W-1:0]       steps;
        logic signed [erg_pkg::ROT_W-1:0]  rot;
        bit                                drain_first;
    } rhythm_req_t;

    // Word as accepted, with the mask it must produce
    typedef struct {
        logic [erg_pkg::COUNT_W-1:0]       hits;
        logic [erg_pkg::COUNT_W-1:0]       steps;
        logic signed [erg_pkg::ROT_W-1:0]  rot;
        logic [erg_pkg::MASK_W-1:0]        mask;
    } rhythm_exp_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [erg_pkg::COUNT_W-1:0]         hit_count = '0;
    logic [erg_pkg::COUNT_W-1:0]         step_count = '0;
    logic signed [erg_pkg::ROT_W-1:0]    rotate_by = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [erg_pkg::MASK_W-1:0]          rhythm_mask;

    rhythm_req_t pending_reqs[$];
    rhythm_exp_t expected_masks[$];
    rhythm_exp_t oldest_mask;
    rhythm_req_t next_req;

    int  cycle_count = 0;
    int  fail_count = 0;
    int  words_sent = 0;
    int  masks_checked = 0;
    int  empty_masks = 0;
    int  full_masks = 0;
    int  drain_pauses = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    logic word_taken;

    euclidean_rhythm_rotate u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hit_count   (hit_count),
        .step_count  (step_count),
        .rotate_by   (rotate_by),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rhythm_mask (rhythm_mask)
    );

    // Clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bucket-fill spread of the hits, then right rotation within the step span
    function automatic logic [erg_pkg::MASK_W-1:0] euclid_pattern(
        input logic [erg_pkg::COUNT_W-1:0]      hits_in,
        input logic [erg_pkg::COUNT_W-1:0]      steps_in,
        input logic signed [erg_pkg::ROT_W-1:0] rot_in
    );
        int unsigned                 hits;
        int unsigned                 steps;
        int unsigned                 fill;
        int unsigned                 shift_amt;
        int                          wrapped;
        logic [erg_pkg::MASK_W-1:0]  span;
        logic [erg_pkg::MASK_W-1:0]  pat;
        hits  = hits_in;
        steps = steps_in;
        if (steps < 1 || steps > erg_pkg::MAX_STEPS)
            return '0;
        if (hits > steps)
            hits = steps;
        if (hits == 0)
            return '0;
        span = (steps >= erg_pkg::MASK_W) ? '1 : ((64'd1 << steps) - 64'd1);
        if (hits == steps)
            pat = span;
        else
        begin
            pat  = '0;
            fill = steps - hits;
            for (int i = 0; i < steps; i++)
            begin
                fill += hits;
                if (fill >= steps)
                begin
                    pat[i] = 1'b1;
                    fill -= steps;
                end
            end
        end
        // signed remainder follows the dividend; fold negatives back in range
        wrapped = int'(rot_in) % int'(steps);
        if (wrapped < 0)
            wrapped += int'(steps);
        shift_amt = wrapped;
        if (shift_amt == 0)
            return pat & span;
        return ((pat >> shift_amt) | (pat << (steps - shift_amt))) & span;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_word(input int hits, input int steps, input int rot,
                              input bit drain_first);
        rhythm_req_t req;
        req.hits        = hits[erg_pkg::COUNT_W-1:0];
        req.steps       = steps[erg_pkg::COUNT_W-1:0];
        req.rot         = rot[erg_pkg::ROT_W-1:0];
        req.drain_first = drain_first;
        pending_reqs.push_back(req);
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
    endtask

    // Driver: presents queued words, holds them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            hit_count  <= '0;
            step_count <= '0;
            rotate_by  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            word_taken = in_valid && !in_stall;
            if (word_taken)
            begin
                rhythm_exp_t item;
                item.hits  = hit_count;
                item.steps = step_count;
                item.rot   = rotate_by;
                item.mask  = euclid_pattern(hit_count, step_count, rotate_by);
                expected_masks.push_back(item);
                words_sent++;
                if (item.mask == '0)
                    empty_masks++;
                if (step_count >= 1 && step_count <= erg_pkg::MAX_STEPS
                    && hit_count >= step_count)
                    full_masks++;
                if ($urandom_range(0, 63) == 0)
                    send_calm <= !send_calm;
            end
            if (in_valid && !word_taken)
            begin
                // stalled: payload holds
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_masks.size() != 0))
            begin
                next_req = pending_reqs.pop_front();
                if (next_req.drain_first)
                    drain_pauses++;
                hit_count  <= next_req.hits;
                step_count <= next_req.steps;
                rotate_by  <= next_req.rot;
                in_valid   <= 1'b1;
                send_gap   <= send_calm ? 0 : idle_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each taken mask against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_masks.size() == 0)
                    note_failure($sformatf("mask %h with no word pending", rhythm_mask));
                else
                begin
                    oldest_mask = expected_masks.pop_front();
                    masks_checked++;
                    if (rhythm_mask !== oldest_mask.mask)
                        note_failure($sformatf(
                            "hits=%0d steps=%0d rot=%0d: expected %h got %h",
                            oldest_mask.hits, oldest_mask.steps, oldest_mask.rot,
                            oldest_mask.mask, rhythm_mask));
                end
            end
            if ($urandom_range(0, 1999) == 0)
                recv_calm <= !recv_calm;
            // random back-pressure
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!recv_calm && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= idle_len();
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int sel;
        int steps;
        int hits;
        int total_words;
        // directed: empty and out-of-range step counts
        queue_word(5, 0, 0, 1'b0);
        queue_word(3, 65, 1, 1'b0);
        queue_word(127, 127, -128, 1'b0);
        // full patterns, largest size
        queue_word(64, 64, 0, 1'b0);
        queue_word(64, 64, 127, 1'b0);
        queue_word(100, 64, -1, 1'b0);
        // basic spread, rotations incl. negative wrap and whole turns
        queue_word(3, 8, 0, 1'b0);
        queue_word(3, 8, 1, 1'b0);
        queue_word(3, 8, -1, 1'b0);
        queue_word(3, 8, 8, 1'b0);
        queue_word(3, 8, -128, 1'b0);
        queue_word(3, 8, -16, 1'b0);
        // clamped hits, no hits, single step
        queue_word(20, 8, 2, 1'b0);
        queue_word(0, 16, 5, 1'b0);
        queue_word(1, 1, -1, 1'b0);
        queue_word(0, 1, 0, 1'b0);
        // large patterns with extreme rotations, then small sizes
        queue_word(1, 64, 127, 1'b0);
        queue_word(63, 64, -128, 1'b0);
        queue_word(33, 64, 64, 1'b1);
        queue_word(127, 63, 127, 1'b0);
        queue_word(5, 13, 0, 1'b0);
        queue_word(2, 5, 0, 1'b0);
        queue_word(7, 12, -5, 1'b0);

        // random: mostly in-range sizes, some raw field values
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                steps = $urandom_range(1, erg_pkg::MAX_STEPS);
                hits  = $urandom_range(0, steps);
            end
            else if (sel < 90)
            begin
                steps = $urandom_range(1, erg_pkg::MAX_STEPS);
                hits  = $urandom_range(0, 127);
            end
            else
            begin
                steps = $urandom_range(0, 127);
                hits  = $urandom_range(0, 127);
            end
            queue_word(hits, steps, $urandom_range(0, 255), $urandom_range(0, 149) == 0);
        end
        total_words = pending_reqs.size();

        // wait until every queued word has come back as a checked mask
        while (masks_checked < total_words)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_masks.size() != 0)
            note_failure($sformatf("%0d masks never arrived", expected_masks.size()));

        $display("Covered %0d words, %0d masks checked (%0d empty, %0d full span)",
                 words_sent, masks_checked, empty_masks, full_masks);
        $display("Sender drained the block %0d times; %0d failures in %0d cycles",
                 drain_pauses, fail_count, cycle_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
